[src/atclp_pkg.sv]
// ----------------------------------------------------------------------------
// AT command line parser package
// Shared types, character codes and sizing constants for the parser.
// ----------------------------------------------------------------------------
package atclp_pkg;

  // Default limit on the number of arguments counted per line.
  localparam int DEFAULT_MAX_ARGS = 16;

  // Depth of the result queue. Two entries are kept free for a new item.
  localparam int RES_FIFO_DEPTH = 4;

  // Configuration register addresses.
  localparam int        PADDR_W          = 2;
  localparam logic [1:0] ADDR_STRICT_CRLF = 2'd0;

  // Character codes.
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_KEYWORD   = 2'd0,
    PH_COMMAND   = 2'd1,
    PH_ARGUMENT  = 2'd2,
    PH_MALFORMED = 2'd3
  } phase_t;

  // Command mode.
  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_TEST  = 2'd3
  } mode_t;

  // Result kind.
  typedef enum logic [1:0] {
    KIND_CMD_CHAR  = 2'd0,
    KIND_ARG_START = 2'd1,
    KIND_ARG_CHAR  = 2'd2,
    KIND_LINE_DONE = 2'd3
  } kind_t;

  // One result item as held in the result queue.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic [3:0] arg_index;
    logic [1:0] line_mode;
    logic       bad_line;
    logic [4:0] arg_total;
    logic       args_dropped;
    logic       last;
  } result_t;

endpackage

[src/at_command_line_parser_top.sv]
// ----------------------------------------------------------------------------
// AT command line parser
// Parses an AT command line one byte per item and streams tagged command
// characters, argument starts, argument characters and a line-done summary.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ----------------------------------------
//  input     in_valid / in_ready     byte_in
//  output    out_valid / out_ready   kind, char_value, arg_index, line_mode,
//                                    bad_line, arg_total, args_dropped, last
//  config    APB psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// A byte is decoded in the cycle it is accepted; its zero, one or two results
// enter a four-entry result queue and the first is visible in the next cycle.
// One byte is taken per cycle as long as the queue holds two or fewer results.
// With the output side taking a result every cycle that always holds, so the
// rate is one byte per cycle; the queue absorbs the extra result of the byte
// that opens the first argument.
// Reset (rst, synchronous) clears the parser state, strict_crlf and the queue.
// A stall on the output side fills the queue and then drops in_ready.
module at_command_line_parser_top #(
  parameter int MAX_ARGS = atclp_pkg::DEFAULT_MAX_ARGS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Byte input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    byte_in,
  // Result output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [7:0]                    char_value,
  output logic [3:0]                    arg_index,
  output logic [1:0]                    line_mode,
  output logic                          bad_line,
  output logic [4:0]                    arg_total,
  output logic                          args_dropped,
  output logic                          last,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [atclp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CNT_W  = $clog2(MAX_ARGS + 1);
  localparam int DEPTH  = atclp_pkg::RES_FIFO_DEPTH;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FCNT_W = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_ARGS);
  localparam logic [FCNT_W-1:0] READY_LIM = FCNT_W'(DEPTH - 2);

  // Parser state
  logic                    strict_crlf;
  atclp_pkg::phase_t       phase, phase_next;
  logic                    prefix_matched, prefix_matched_next;
  atclp_pkg::mode_t        mode_reg, mode_reg_next;
  logic [CNT_W-1:0]        arg_counter, arg_counter_next;
  logic                    overflow_flag, overflow_flag_next;
  logic [7:0]              previous_byte, previous_byte_next;

  // Result queue
  atclp_pkg::result_t      fifo_mem [DEPTH];
  logic [PTR_W-1:0]        wr_ptr, rd_ptr;
  logic [FCNT_W-1:0]       fifo_count, fifo_count_next;

  logic                    in_accept;
  logic                    out_accept;

  // Byte classes
  logic is_lf, is_cr, is_quote, is_comma, is_qmark, is_equal;
  logic line_end;
  logic cmd_plain;
  logic first_open;
  logic arg_step;
  logic open_a_ok;
  logic [CNT_W-1:0] cnt_a;
  logic             ovf_a;
  logic arg_drop;
  logic open_b_ok;
  logic [CNT_W-1:0] cnt_b;
  logic             ovf_b;
  logic char_b_ok;

  // Counter values widened so the low bits can be taken at any CNT_W
  logic [CNT_W+4:0] cnt_ext;
  logic [CNT_W+4:0] cnt_a_ext;
  logic [CNT_W+4:0] cnt_a_m1_ext;

  atclp_pkg::result_t res_a, res_b, push0, push1;
  logic               res_a_vld, res_b_vld;
  logic [1:0]         push_n;

  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  // Configuration port: always ready, one register.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == atclp_pkg::ADDR_STRICT_CRLF) begin
      prdata[0] = strict_crlf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_crlf <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == atclp_pkg::ADDR_STRICT_CRLF) begin
      strict_crlf <= pwdata[0];
    end
  end

  // Decode of the incoming byte against the current state.
  always_comb begin
    is_lf    = (byte_in == atclp_pkg::CH_LF);
    is_cr    = (byte_in == atclp_pkg::CH_CR);
    is_quote = (byte_in == atclp_pkg::CH_QUOTE);
    is_comma = (byte_in == atclp_pkg::CH_COMMA);
    is_qmark = (byte_in == atclp_pkg::CH_QMARK);
    is_equal = (byte_in == atclp_pkg::CH_EQUAL);

    if (strict_crlf) begin
      line_end = (previous_byte == atclp_pkg::CH_CR) && is_lf;
    end else begin
      line_end = is_lf;
    end

    // A plain command-phase byte: not a mode character and not CR or LF.
    cmd_plain  = !line_end && (phase == atclp_pkg::PH_COMMAND) &&
                 !is_qmark && !is_equal && !is_cr && !is_lf;
    first_open = cmd_plain && (mode_reg != atclp_pkg::MODE_RUN);
    arg_step   = first_open || (!line_end && phase == atclp_pkg::PH_ARGUMENT);

    // First step: the argument opened by the first argument byte.
    open_a_ok = arg_counter < MAX_CNT;
    cnt_a     = (first_open && open_a_ok) ? arg_counter + CNT_W'(1) : arg_counter;
    ovf_a     = overflow_flag || (first_open && !open_a_ok);

    // Second step: the byte itself as an argument byte.
    arg_drop  = is_quote || is_cr || is_lf;
    open_b_ok = cnt_a < MAX_CNT;
    cnt_b     = cnt_a;
    ovf_b     = ovf_a;
    if (arg_step && !arg_drop && is_comma) begin
      if (open_b_ok) begin
        cnt_b = cnt_a + CNT_W'(1);
      end else begin
        ovf_b = 1'b1;
      end
    end
    char_b_ok = !ovf_a && (cnt_a != '0);

    cnt_ext      = {5'd0, arg_counter};
    cnt_a_ext    = {5'd0, cnt_a};
    cnt_a_m1_ext = {5'd0, cnt_a - CNT_W'(1)};
  end

  // Next parser state.
  always_comb begin
    phase_next          = phase;
    prefix_matched_next = prefix_matched;
    mode_reg_next       = mode_reg;
    arg_counter_next    = cnt_b;
    overflow_flag_next  = ovf_b;
    previous_byte_next  = byte_in;

    if (line_end) begin
      phase_next          = atclp_pkg::PH_KEYWORD;
      prefix_matched_next = 1'b0;
      mode_reg_next       = atclp_pkg::MODE_RUN;
      arg_counter_next    = '0;
      overflow_flag_next  = 1'b0;
      previous_byte_next  = '0;
    end else begin
      case (phase)
        atclp_pkg::PH_KEYWORD: begin
          if (byte_in != (prefix_matched ? atclp_pkg::CH_T : atclp_pkg::CH_A)) begin
            phase_next = atclp_pkg::PH_MALFORMED;
          end else if (prefix_matched) begin
            phase_next = atclp_pkg::PH_COMMAND;
          end else begin
            prefix_matched_next = 1'b1;
          end
        end
        atclp_pkg::PH_COMMAND: begin
          if (is_qmark) begin
            case (mode_reg)
              atclp_pkg::MODE_RUN:   mode_reg_next = atclp_pkg::MODE_READ;
              atclp_pkg::MODE_WRITE: mode_reg_next = atclp_pkg::MODE_TEST;
              default:               phase_next    = atclp_pkg::PH_MALFORMED;
            endcase
          end else if (is_equal) begin
            if (mode_reg == atclp_pkg::MODE_RUN) begin
              mode_reg_next = atclp_pkg::MODE_WRITE;
            end else begin
              phase_next = atclp_pkg::PH_MALFORMED;
            end
          end else if (first_open) begin
            phase_next = atclp_pkg::PH_ARGUMENT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Results caused by the byte: at most two, in order.
  always_comb begin
    res_a     = '0;
    res_b     = '0;
    res_a_vld = 1'b0;
    res_b_vld = 1'b0;

    if (line_end) begin
      res_a_vld          = 1'b1;
      res_a.kind         = atclp_pkg::KIND_LINE_DONE;
      res_a.line_mode    = mode_reg;
      res_a.bad_line     = (phase == atclp_pkg::PH_MALFORMED);
      res_a.arg_total    = cnt_ext[4:0];
      res_a.args_dropped = overflow_flag;
    end else if (cmd_plain && !first_open) begin
      res_a_vld        = 1'b1;
      res_a.kind       = atclp_pkg::KIND_CMD_CHAR;
      res_a.char_value = byte_in;
    end else if (first_open && open_a_ok) begin
      res_a_vld       = 1'b1;
      res_a.kind      = atclp_pkg::KIND_ARG_START;
      res_a.arg_index = cnt_ext[3:0];
    end

    if (arg_step && !arg_drop) begin
      if (is_comma) begin
        if (open_b_ok) begin
          res_b_vld       = 1'b1;
          res_b.kind      = atclp_pkg::KIND_ARG_START;
          res_b.arg_index = cnt_a_ext[3:0];
        end
      end else if (char_b_ok) begin
        res_b_vld        = 1'b1;
        res_b.kind       = atclp_pkg::KIND_ARG_CHAR;
        res_b.char_value = byte_in;
        res_b.arg_index  = cnt_a_m1_ext[3:0];
      end
    end

    // Pack the valid results to the front and mark the final one.
    push0  = res_a_vld ? res_a : res_b;
    push1  = res_b;
    push_n = 2'(res_a_vld) + 2'(res_b_vld);
    if (push_n == 2'd1) begin
      push0.last = 1'b1;
    end
    push1.last = 1'b1;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= atclp_pkg::PH_KEYWORD;
      prefix_matched <= 1'b0;
      mode_reg       <= atclp_pkg::MODE_RUN;
      arg_counter    <= '0;
      overflow_flag  <= 1'b0;
      previous_byte  <= '0;
    end else if (in_accept) begin
      phase          <= phase_next;
      prefix_matched <= prefix_matched_next;
      mode_reg       <= mode_reg_next;
      arg_counter    <= arg_counter_next;
      overflow_flag  <= overflow_flag_next;
      previous_byte  <= previous_byte_next;
    end
  end

  // Result queue control.
  assign in_ready  = (fifo_count <= READY_LIM);
  assign out_valid = (fifo_count != '0);

  always_comb begin
    fifo_count_next = fifo_count;
    if (in_accept) begin
      fifo_count_next = fifo_count_next + FCNT_W'(push_n);
    end
    if (out_accept) begin
      fifo_count_next = fifo_count_next - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      fifo_count <= fifo_count_next;
      if (in_accept) begin
        wr_ptr <= wr_ptr + PTR_W'(push_n);
      end
      if (out_accept) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  // Result queue storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_accept && push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= push0;
    end
    if (in_accept && push_n == 2'd2) begin
      fifo_mem[wr_ptr + PTR_W'(1)] <= push1;
    end
  end

  // Output fields come straight from the head of the queue.
  assign kind         = fifo_mem[rd_ptr].kind;
  assign char_value   = fifo_mem[rd_ptr].char_value;
  assign arg_index    = fifo_mem[rd_ptr].arg_index;
  assign line_mode    = fifo_mem[rd_ptr].line_mode;
  assign bad_line     = fifo_mem[rd_ptr].bad_line;
  assign arg_total    = fifo_mem[rd_ptr].arg_total;
  assign args_dropped = fifo_mem[rd_ptr].args_dropped;
  assign last         = fifo_mem[rd_ptr].last;

endmodule
